/* src/rau_pkg.sv */
// Shared codes for the rational arithmetic unit.
package rau_pkg;

    localparam int REQ_W = 3;
    localparam int CMP_W = 2;
    localparam int STS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] OP_REDUCE = 3'd0;
    localparam logic [REQ_W-1:0] OP_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] OP_SUB    = 3'd2;
    localparam logic [REQ_W-1:0] OP_MUL    = 3'd3;
    localparam logic [REQ_W-1:0] OP_DIV    = 3'd4;
    localparam logic [REQ_W-1:0] OP_CMP    = 3'd5;

    // compare codes
    localparam logic [CMP_W-1:0] CMP_EQ = 2'd0;
    localparam logic [CMP_W-1:0] CMP_LT = 2'd1;
    localparam logic [CMP_W-1:0] CMP_GT = 2'd2;

    // status codes
    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_ZERO = 2'd1;
    localparam logic [STS_W-1:0] STS_OVF  = 2'd2;

endpackage

/* src/rau_req_if.sv */
// Request channel: operation code and two fractions.
interface rau_req_if import rau_pkg::*; #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic        [REQ_W-1:0]      req_type;
    logic signed [DATA_WIDTH-1:0] a_num;
    logic signed [DATA_WIDTH-1:0] a_den;
    logic signed [DATA_WIDTH-1:0] b_num;
    logic signed [DATA_WIDTH-1:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

/* src/rau_rsp_if.sv */
// Response channel: result fraction, compare code and status.
interface rau_rsp_if import rau_pkg::*; #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_num;
    logic signed [DATA_WIDTH-1:0] res_den;
    logic        [CMP_W-1:0]      cmp_result;
    logic        [STS_W-1:0]      status;

    modport source (output valid, res_num, res_den, cmp_result, status, input ready);
    modport sink   (input valid, res_num, res_den, cmp_result, status, output ready);
endinterface

/* src/rational_arith_unit.sv */
// Rational arithmetic unit: sequencer around one shared add/subtract unit.
//
//   channel  dir  handshake        payload
//   i_req    in   valid/ready      req_type, a_num, a_den, b_num, b_den
//   o_rsp    out  valid/ready      res_num, res_den, cmp_result, status
//
// W = DATA_WIDTH. Add/sub runs binary GCD, g shift-back, two restoring
// divisions and three shift-add products; reduce stops after the divisions;
// multiply/divide run three products and compare two; errors and unused
// codes go straight to write-back. One (W+1)-bit adder/subtractor serves
// the GCD subtract, division and product steps.
// Synchronous active-low reset clears the sequencer and output valid.
// i_req is taken only while idle; a result held by o_rsp stalls only the
// final write-back, so the next transaction may already be accepted.
module rational_arith_unit import rau_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rau_req_if.sink i_req,
    rau_rsp_if.source o_rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);
    localparam int SW = 2 * DATA_WIDTH + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_GSH  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MLD  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state;
    logic [REQ_W-1:0] r_op;
    logic             r_zero, r_unused;
    logic [W-1:0]     r_an, r_ad, r_bn, r_bd;
    logic             r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [W-1:0]     r_ga, r_gb;
    logic [CW-1:0]    r_k, r_cnt;
    logic [W-1:0]     r_rem, r_dq, r_q0, r_q1;
    logic             r_didx;
    logic [1:0]       r_midx;
    logic [W-1:0]     r_ma, r_mb;
    logic [2*W-1:0]   r_prod, r_p0, r_p1, r_p2;

    logic             r_ovalid;
    logic [W-1:0]     r_res_num, r_res_den;
    logic [CMP_W-1:0] r_cmp;
    logic [STS_W-1:0] r_sts;

    // input decode
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic         in_zero, in_unused;

    always_comb begin
        in_an = i_req.a_num[W-1] ? (~$unsigned(i_req.a_num) + 1'b1) : $unsigned(i_req.a_num);
        in_ad = i_req.a_den[W-1] ? (~$unsigned(i_req.a_den) + 1'b1) : $unsigned(i_req.a_den);
        in_bn = i_req.b_num[W-1] ? (~$unsigned(i_req.b_num) + 1'b1) : $unsigned(i_req.b_num);
        in_bd = i_req.b_den[W-1] ? (~$unsigned(i_req.b_den) + 1'b1) : $unsigned(i_req.b_den);
        in_unused = (i_req.req_type > OP_CMP);
        in_zero   = (in_ad == '0)
                  || ((i_req.req_type != OP_REDUCE) && (in_bd == '0))
                  || ((i_req.req_type == OP_DIV) && (in_bn == '0));
    end

    assign i_req.ready = (r_state == S_IDLE);

    // shared adder/subtractor
    logic [W:0] au_x, au_y, au_r;
    logic       au_sub;

    always_comb begin
        au_x   = '0;
        au_y   = '0;
        au_sub = 1'b0;
        unique case (r_state)
            S_GCD: begin
                au_x   = {1'b0, r_ga};
                au_y   = {1'b0, r_gb};
                au_sub = 1'b1;
            end
            S_DIV: begin
                au_x   = {r_rem, r_dq[W-1]};
                au_y   = {1'b0, r_ga};
                au_sub = 1'b1;
            end
            S_MUL: begin
                au_x = {1'b0, r_prod[2*W-1:W]};
                au_y = r_mb[0] ? {1'b0, r_ma} : '0;
            end
            default: begin
                au_x = '0;
            end
        endcase
        au_r = au_x + (au_sub ? ~au_y : au_y) + {{W{1'b0}}, au_sub};
    end

    // product operand select
    logic [W-1:0] c_ma, c_mb;
    logic         is_addsub;
    assign is_addsub = (r_op == OP_ADD) || (r_op == OP_SUB);

    always_comb begin
        c_ma = '0;
        c_mb = '0;
        unique case (r_midx)
            2'd0: begin
                c_ma = r_an;
                c_mb = is_addsub ? r_q0 : ((r_op == OP_MUL) ? r_bn : r_bd);
            end
            2'd1: begin
                if (is_addsub) begin
                    c_ma = r_bn;
                    c_mb = r_q1;
                end else if (r_op == OP_CMP) begin
                    c_ma = r_bn;
                    c_mb = r_ad;
                end
            end
            2'd2: begin
                c_ma = r_ad;
                c_mb = is_addsub ? r_q0 : ((r_op == OP_DIV) ? r_bn : r_bd);
            end
            default: begin
                c_ma = '0;
            end
        endcase
    end

    // final combine
    logic             s0, s1, s2;
    logic [SW-1:0]    e0, e1, e2, v0, v1, f_sum, f_den_full;
    logic [W+2:0]     f_hi_n, f_hi_d;
    logic             f_fit, f_neg, f_nz, f_flip, f_lt, f_gt;
    logic [W-1:0]     f_num, f_den;
    logic [CMP_W-1:0] f_cmp;
    logic [STS_W-1:0] f_sts;

    always_comb begin
        s0 = r_an_s ^ ((r_op == OP_MUL) ? r_bn_s : r_bd_s);
        s1 = r_bn_s ^ r_ad_s ^ ((r_op == OP_SUB) || (r_op == OP_CMP));
        s2 = r_ad_s ^ ((r_op == OP_DIV) ? r_bn_s : r_bd_s);
        e0 = {2'b00, r_p0};
        e1 = {2'b00, r_p1};
        e2 = {2'b00, r_p2};
        v0 = s0 ? (~e0 + 1'b1) : e0;
        v1 = s1 ? (~e1 + 1'b1) : e1;
        f_sum      = v0 + v1;
        f_den_full = s2 ? (~e2 + 1'b1) : e2;
        f_hi_n = f_sum[SW-1:W-1];
        f_hi_d = f_den_full[SW-1:W-1];
        f_fit  = ((&f_hi_n) || !(|f_hi_n)) && ((&f_hi_d) || !(|f_hi_d));
        f_neg  = f_sum[SW-1];
        f_nz   = |f_sum;
        f_flip = r_ad_s ^ r_bd_s;
        f_lt   = f_flip ? (!f_neg && f_nz) : f_neg;
        f_gt   = f_flip ? f_neg : (!f_neg && f_nz);

        f_num = '0;
        f_den = '0;
        f_cmp = CMP_EQ;
        f_sts = STS_OK;
        priority if (r_unused) begin
            f_sts = STS_OK;
        end else if (r_zero) begin
            f_sts = STS_ZERO;
        end else if (r_op == OP_REDUCE) begin
            f_num = r_an_s ? (~r_q0 + 1'b1) : r_q0;
            f_den = r_ad_s ? (~r_q1 + 1'b1) : r_q1;
        end else if (r_op == OP_CMP) begin
            f_cmp = f_lt ? CMP_LT : (f_gt ? CMP_GT : CMP_EQ);
        end else begin
            f_num = f_sum[W-1:0];
            f_den = f_den_full[W-1:0];
            f_sts = f_fit ? STS_OK : STS_OVF;
        end
    end

    logic [W-1:0] dq_next;
    assign dq_next = {r_dq[W-2:0], !au_r[W]};

    // result register loads when empty or draining this cycle
    logic fin_load;
    assign fin_load = (r_state == S_FIN) && (!r_ovalid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= i_req.req_type;
                        r_zero   <= in_zero;
                        r_unused <= in_unused;
                        r_an     <= in_an;
                        r_ad     <= in_ad;
                        r_bn     <= in_bn;
                        r_bd     <= in_bd;
                        r_an_s   <= i_req.a_num[W-1];
                        r_ad_s   <= i_req.a_den[W-1];
                        r_bn_s   <= i_req.b_num[W-1];
                        r_bd_s   <= i_req.b_den[W-1];
                        r_k      <= '0;
                        r_midx   <= 2'd0;
                        r_ga     <= (i_req.req_type == OP_REDUCE) ? in_an : in_ad;
                        r_gb     <= (i_req.req_type == OP_REDUCE) ? in_ad : in_bd;
                        if (in_unused || in_zero) begin
                            r_state <= S_FIN;
                        end else if (i_req.req_type <= OP_SUB) begin
                            r_state <= S_GCD;
                        end else begin
                            r_state <= S_MLD;
                        end
                    end
                end
                S_GCD: begin
                    // binary gcd, one step per cycle
                    if ((r_ga == '0) || (r_gb == '0)) begin
                        r_ga    <= r_ga | r_gb;
                        r_state <= S_GSH;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + 1'b1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (!au_r[W]) begin
                        r_ga <= au_r[W-1:0];
                    end else begin
                        r_ga <= r_gb;
                        r_gb <= r_ga;
                    end
                end
                S_GSH: begin
                    if (r_k == '0) begin
                        r_dq    <= (r_op == OP_REDUCE) ? r_an : r_bd;
                        r_rem   <= '0;
                        r_cnt   <= CW'(W - 1);
                        r_didx  <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_ga <= r_ga << 1;
                        r_k  <= r_k - 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_rem <= au_r[W] ? au_x[W-1:0] : au_r[W-1:0];
                        r_dq  <= dq_next;
                        r_cnt <= r_cnt - 1'b1;
                    end else if (!r_didx) begin
                        r_q0   <= dq_next;
                        r_dq   <= r_ad;
                        r_rem  <= '0;
                        r_cnt  <= CW'(W - 1);
                        r_didx <= 1'b1;
                    end else begin
                        r_q1    <= dq_next;
                        r_midx  <= 2'd0;
                        r_state <= (r_op == OP_REDUCE) ? S_FIN : S_MLD;
                    end
                end
                S_MLD: begin
                    r_ma    <= c_ma;
                    r_mb    <= c_mb;
                    r_prod  <= '0;
                    r_cnt   <= CW'(W - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= {au_r, r_prod[W-1:1]};
                    r_mb   <= r_mb >> 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        unique case (r_midx)
                            2'd0:    r_p0 <= {au_r, r_prod[W-1:1]};
                            2'd1:    r_p1 <= {au_r, r_prod[W-1:1]};
                            default: r_p2 <= {au_r, r_prod[W-1:1]};
                        endcase
                        if ((r_midx == 2'd2) || ((r_op == OP_CMP) && (r_midx == 2'd1))) begin
                            r_state <= S_FIN;
                        end else begin
                            r_midx  <= r_midx + 1'b1;
                            r_state <= S_MLD;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_res_num <= f_num;
                        r_res_den <= f_den;
                        r_cmp     <= f_cmp;
                        r_sts     <= f_sts;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.res_num    = $signed(r_res_num);
    assign o_rsp.res_den    = $signed(r_res_den);
    assign o_rsp.cmp_result = r_cmp;
    assign o_rsp.status     = r_sts;

endmodule
